// ----- hdl/kcl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code lock package
// Shared types, codes and the keypad decode table for the code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int CODE_DIGITS_DEF = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_TRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 2'd1;

  localparam logic [3:0]  FREE_TRIES_RST = 4'd3;
  localparam logic [15:0] LOCKOUT_RST    = 16'd60;
  localparam logic [4:0]  FAIL_MAX       = 5'd31;

  // Encoded phase values as seen on the result port.
  localparam logic [2:0] PHASE_SET     = 3'd0;
  localparam logic [2:0] PHASE_ENTER   = 3'd1;
  localparam logic [2:0] PHASE_UNLOCK  = 3'd2;
  localparam logic [2:0] PHASE_TIMED   = 3'd3;
  localparam logic [2:0] PHASE_FOREVER = 3'd4;

  typedef enum logic [4:0] {
    PH_SET     = 5'b00001,
    PH_ENTER   = 5'b00010,
    PH_UNLOCK  = 5'b00100,
    PH_TIMED   = 5'b01000,
    PH_FOREVER = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DIGIT   = 3'd1,
    EV_SET     = 3'd2,
    EV_CORRECT = 3'd3,
    EV_WRONG   = 3'd4,
    EV_LOCKOUT = 3'd5,
    EV_PERM    = 3'd6,
    EV_OVER    = 3'd7
  } event_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_eq;
    logic [3:0] digit;
  } key_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  fail_cnt;
    logic [15:0] countdown;
  } ctrl_t;

  typedef struct packed {
    logic [2:0]  phase;
    event_t      ev;
    logic [2:0]  digits;
    logic [4:0]  failures;
    logic [15:0] seconds_left;
    logic        alarm;
  } res_t;

  // Raw 4x4 keypad scan code to digit or equals.
  function automatic key_t key_decode(input logic [4:0] raw);
    key_t k;
    k = '{is_digit: 1'b1, is_eq: 1'b0, digit: 4'd0};
    unique case (raw)
      5'd1:    k.digit = 4'd7;
      5'd2:    k.digit = 4'd4;
      5'd3:    k.digit = 4'd1;
      5'd5:    k.digit = 4'd8;
      5'd6:    k.digit = 4'd5;
      5'd7:    k.digit = 4'd2;
      5'd8:    k.digit = 4'd0;
      5'd9:    k.digit = 4'd9;
      5'd10:   k.digit = 4'd6;
      5'd11:   k.digit = 4'd3;
      5'd12: begin
        k.is_digit = 1'b0;
        k.is_eq    = 1'b1;
      end
      default: k.is_digit = 1'b0;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] c;
    c = PHASE_SET;
    unique case (ph)
      PH_SET:     c = PHASE_SET;
      PH_ENTER:   c = PHASE_ENTER;
      PH_UNLOCK:  c = PHASE_UNLOCK;
      PH_TIMED:   c = PHASE_TIMED;
      PH_FOREVER: c = PHASE_FOREVER;
      default:    c = PHASE_SET;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/kcl_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Code lock step logic
// Next-state and result logic for one keypad press or one second tick.
// ----------------------------------------------------------------------------
module kcl_step #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF,
  parameter int IDX_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
) (
  input  kcl_pkg::ctrl_t                  cur,
  input  logic [IDX_W-1:0]                idx,
  input  logic [CODE_DIGITS-1:0][3:0]     stored_code,
  input  logic [CODE_DIGITS-1:0][3:0]     entry_digits,
  input  logic                            op,
  input  logic [4:0]                      key_code,
  input  logic [3:0]                      free_tries,
  input  logic [15:0]                     lockout_seconds,
  output kcl_pkg::ctrl_t                  nxt,
  output logic [IDX_W-1:0]                idx_next,
  output logic                            code_we,
  output logic                            entry_we,
  output logic [3:0]                      digit,
  output kcl_pkg::res_t                   res
);
  import kcl_pkg::*;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(CODE_DIGITS - 1);

  key_t                        key;
  logic                        judge;
  logic                        full;
  logic                        match;
  logic [4:0]                  fail_inc;
  logic [4:0]                  tries_ext;
  logic [15:0]                 cnt_dec;
  logic [CODE_DIGITS-1:0][3:0] cand;
  event_t                      ev;

  assign key       = key_decode(key_code);
  assign digit     = key.digit;
  assign tries_ext = {1'b0, free_tries};
  assign fail_inc  = (cur.fail_cnt == FAIL_MAX) ? FAIL_MAX : cur.fail_cnt + 5'd1;
  assign cnt_dec   = (cur.countdown != 16'd0) ? cur.countdown - 16'd1 : 16'd0;

  // The final digit of an entry is compared as it arrives.
  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      cand[i] = (IDX_W'(i) == idx) ? key.digit : entry_digits[i];
    end
  end

  always_comb begin
    nxt      = cur;
    idx_next = idx;
    code_we  = 1'b0;
    entry_we = 1'b0;
    judge    = 1'b0;
    full     = 1'b0;
    match    = 1'b0;
    ev       = EV_NONE;

    if (op) begin
      if (cur.phase == PH_TIMED) begin
        nxt.countdown = cnt_dec;
        if (cnt_dec == 16'd0) begin
          nxt.phase = PH_ENTER;
          ev        = EV_OVER;
        end
      end
    end else begin
      unique case (cur.phase)
        PH_SET: begin
          if (key.is_digit) begin
            code_we = 1'b1;
            if (idx == LAST) begin
              idx_next  = '0;
              nxt.phase = PH_ENTER;
              ev        = EV_SET;
            end else begin
              idx_next = idx + IDX_W'(1);
              ev       = EV_DIGIT;
            end
          end
        end
        PH_ENTER: begin
          if (key.is_eq) begin
            judge = 1'b1;
          end else if (key.is_digit) begin
            entry_we = 1'b1;
            if (idx == LAST) begin
              judge = 1'b1;
              full  = 1'b1;
            end else begin
              idx_next = idx + IDX_W'(1);
              ev       = EV_DIGIT;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (judge) begin
      idx_next = '0;
      match    = full && (cand == stored_code);
      if (match) begin
        nxt.phase    = PH_UNLOCK;
        nxt.fail_cnt = 5'd0;
        ev           = EV_CORRECT;
      end else begin
        nxt.fail_cnt = fail_inc;
        if (fail_inc <= tries_ext) begin
          ev = EV_WRONG;
        end else if (fail_inc == tries_ext + 5'd1) begin
          nxt.countdown = lockout_seconds;
          nxt.phase     = (lockout_seconds != 16'd0) ? PH_TIMED : PH_ENTER;
          ev            = EV_LOCKOUT;
        end else begin
          nxt.phase = PH_FOREVER;
          ev        = EV_PERM;
        end
      end
    end
  end

  always_comb begin
    res.phase        = phase_code(nxt.phase);
    res.ev           = ev;
    res.digits       = 3'(idx_next);
    res.failures     = nxt.fail_cnt;
    res.seconds_left = (nxt.phase == PH_TIMED) ? nxt.countdown : 16'd0;
    res.alarm        = (nxt.phase == PH_FOREVER);
  end

endmodule

// ----- hdl/keypad_code_lock_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code lock unit
// An accepted beat enters the input register; its result leaves the result
// register. Throughput: one beat per cycle unless the result side stalls;
// both form a two-stage pipeline, and the lock state updates in one pass.
// Reset: synchronous, returns to code setting with no failures and the
// default free tries (3) and lockout length (60 ticks).
// ----------------------------------------------------------------------------
module keypad_code_lock_unit #(
  parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [4:0]                        key_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        phase,
  output logic [2:0]                        event_res,
  output logic [2:0]                        digits_entered,
  output logic [4:0]                        failures,
  output logic [15:0]                       seconds_left,
  output logic                              alarm,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kcl_pkg::*;

  localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  logic [3:0]                  free_tries;
  logic [15:0]                 lockout_seconds;

  logic                        s1_valid;
  logic                        s1_op;
  logic [4:0]                  s1_key;
  logic                        advance;

  ctrl_t                       ctrl;
  ctrl_t                       ctrl_next;
  logic [IDX_W-1:0]            dig_idx;
  logic [IDX_W-1:0]            dig_idx_next;
  logic [CODE_DIGITS-1:0][3:0] stored_code;
  logic [CODE_DIGITS-1:0][3:0] entry_digits;
  logic                        code_we;
  logic                        entry_we;
  logic [3:0]                  digit;
  res_t                        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_tries      <= FREE_TRIES_RST;
      lockout_seconds <= LOCKOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FREE_TRIES) begin
        free_tries <= cfg_data[3:0];
      end else if (cfg_index == CFG_LOCKOUT) begin
        lockout_seconds <= cfg_data[15:0];
      end
    end
  end

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op  <= op;
      s1_key <= key_code;
    end
  end

  kcl_step #(
    .CODE_DIGITS (CODE_DIGITS),
    .IDX_W       (IDX_W)
  ) u_step (
    .cur             (ctrl),
    .idx             (dig_idx),
    .stored_code     (stored_code),
    .entry_digits    (entry_digits),
    .op              (s1_op),
    .key_code        (s1_key),
    .free_tries      (free_tries),
    .lockout_seconds (lockout_seconds),
    .nxt             (ctrl_next),
    .idx_next        (dig_idx_next),
    .code_we         (code_we),
    .entry_we        (entry_we),
    .digit           (digit),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl    <= '{phase: PH_SET, fail_cnt: 5'd0, countdown: 16'd0};
      dig_idx <= '0;
    end else if (advance) begin
      ctrl    <= ctrl_next;
      dig_idx <= dig_idx_next;
    end
  end

  // The code store and the entry buffer are always filled before they are read.
  always_ff @(posedge clk) begin
    if (advance && code_we) begin
      stored_code[dig_idx] <= digit;
    end
    if (advance && entry_we) begin
      entry_digits[dig_idx] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      phase          <= res.phase;
      event_res      <= res.ev;
      digits_entered <= res.digits;
      failures       <= res.failures;
      seconds_left   <= res.seconds_left;
      alarm          <= res.alarm;
    end
  end

  a_forever_sticks: assert property (@(posedge clk) disable iff (rst)
    (ctrl.phase == PH_FOREVER) |=> (ctrl.phase == PH_FOREVER))
    else $error("permanent lock was left");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (int'(dig_idx) < CODE_DIGITS))
    else $error("digit index out of range");

  a_seconds_timed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seconds_left != 16'd0) |-> (phase == PHASE_TIMED))
    else $error("seconds left shown outside timed lock");

  a_correct_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_CORRECT) |-> (failures == 5'd0 && phase == PHASE_UNLOCK))
    else $error("correct entry did not unlock and clear failures");

endmodule

// ----- tb/kcl_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code lock test package
// Item kinds, raw keypad codes and sizes shared by the stimulus and the
// checker of the keypad code lock test.
// ----------------------------------------------------------------------------
package kcl_tb_pkg;

  localparam int DIGITS = kcl_pkg::CODE_DIGITS_DEF;

  // Item kinds on the op field.
  localparam logic OP_PRESS = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [4:0] KEY_NONE_RAW = 5'd0;
  localparam logic [4:0] KEY_EQ_RAW   = 5'd12;

  // Raw scan code of each digit, indexed by the digit value.
  localparam logic [9:0][4:0] DIGIT_RAWS = {
    5'd9, 5'd5, 5'd1, 5'd10, 5'd6, 5'd2, 5'd11, 5'd7, 5'd3, 5'd8
  };

endpackage

// ----- tb/keypad_code_lock_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code lock checker
// Watches the input, result and register channels of the code lock, keeps
// its own copy of the lock state, and compares every result beat with the
// oldest predicted result.
// ----------------------------------------------------------------------------
module keypad_code_lock_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           op,
  input  logic [4:0]                     key_code,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [2:0]                     phase,
  input  logic [2:0]                     event_res,
  input  logic [2:0]                     digits_entered,
  input  logic [4:0]                     failures,
  input  logic [15:0]                    seconds_left,
  input  logic                           alarm,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             outstanding
);
  import kcl_pkg::*;
  import kcl_tb_pkg::*;

  localparam int KEY_IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef struct packed {
    logic       digit_key;
    logic       equals_key;
    logic [3:0] value;
  } press_t;

  logic [2:0]  lock_state;
  logic [3:0]  secret [DIGITS];
  logic [3:0]  attempt [DIGITS];
  logic [2:0]  key_count;
  logic [4:0]  miss_count;
  logic [15:0] lock_timer;
  logic [3:0]  tries_allowed;
  logic [15:0] lockout_len;

  res_t pending_results [$];
  int   mismatches = 0;

  assign fail_count = mismatches;

  function automatic press_t decode_press(input logic [4:0] raw);
    press_t p;
    p = '{digit_key: 1'b0, equals_key: 1'b0, value: 4'd0};
    if (raw == KEY_EQ_RAW) begin
      p.equals_key = 1'b1;
    end else begin
      for (int d = 0; d < 10; d++) begin
        if (raw == DIGIT_RAWS[d]) begin
          p.digit_key = 1'b1;
          p.value     = 4'(d);
        end
      end
    end
    return p;
  endfunction

  // Judges the entry held so far and clears it.
  task automatic close_entry(output event_t ev);
    logic agree;
    agree = (key_count == DIGITS);
    for (int i = 0; i < DIGITS; i++) begin
      if (attempt[i] != secret[i]) agree = 1'b0;
    end
    key_count = '0;
    if (agree) begin
      lock_state = PHASE_UNLOCK;
      miss_count = '0;
      ev = EV_CORRECT;
    end else begin
      if (miss_count != FAIL_MAX) miss_count++;
      if (miss_count <= {1'b0, tries_allowed}) begin
        ev = EV_WRONG;
      end else if (miss_count == {1'b0, tries_allowed} + 5'd1) begin
        lock_timer = lockout_len;
        lock_state = (lock_timer != '0) ? PHASE_TIMED : PHASE_ENTER;
        ev = EV_LOCKOUT;
      end else begin
        lock_state = PHASE_FOREVER;
        ev = EV_PERM;
      end
    end
  endtask

  task automatic advance_lock(input logic kind, input logic [4:0] raw, output res_t r);
    press_t k;
    event_t ev;
    k  = decode_press(raw);
    ev = EV_NONE;
    if (kind == OP_TICK) begin
      if (lock_state == PHASE_TIMED) begin
        if (lock_timer != '0) lock_timer--;
        if (lock_timer == '0) begin
          lock_state = PHASE_ENTER;
          ev = EV_OVER;
        end
      end
    end else if (k.digit_key || k.equals_key) begin
      if (lock_state == PHASE_SET) begin
        if (k.digit_key && key_count < DIGITS) begin
          secret[KEY_IDX_W'(key_count)] = k.value;
          key_count++;
          ev = EV_DIGIT;
          if (key_count >= DIGITS) begin
            key_count  = '0;
            lock_state = PHASE_ENTER;
            ev = EV_SET;
          end
        end
      end else if (lock_state == PHASE_ENTER) begin
        if (k.equals_key) begin
          close_entry(ev);
        end else if (key_count < DIGITS) begin
          attempt[KEY_IDX_W'(key_count)] = k.value;
          key_count++;
          ev = EV_DIGIT;
          if (key_count >= DIGITS) close_entry(ev);
        end
      end
    end
    r.phase        = lock_state;
    r.ev           = ev;
    r.digits       = key_count;
    r.failures     = miss_count;
    r.seconds_left = (lock_state == PHASE_TIMED) ? lock_timer : '0;
    r.alarm        = (lock_state == PHASE_FOREVER);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      lock_state    = PHASE_SET;
      key_count     = '0;
      miss_count    = '0;
      lock_timer    = '0;
      tries_allowed = FREE_TRIES_RST;
      lockout_len   = LOCKOUT_RST;
      for (int i = 0; i < DIGITS; i++) begin
        secret[i]  = '0;
        attempt[i] = '0;
      end
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FREE_TRIES: tries_allowed = cfg_data[3:0];
          CFG_LOCKOUT:    lockout_len   = cfg_data[15:0];
          default: ;
        endcase
      end
      // The result beat is matched before this edge's input beat is added.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no result expected");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("phase", 32'(want.phase), 32'(phase));
          check_field("event_res", int'(want.ev), 32'(event_res));
          check_field("digits_entered", 32'(want.digits), 32'(digits_entered));
          check_field("failures", 32'(want.failures), 32'(failures));
          check_field("seconds_left", 32'(want.seconds_left), 32'(seconds_left));
          check_field("alarm", 32'(want.alarm), 32'(alarm));
        end
      end
      if (in_valid && in_ready) begin
        advance_lock(op, key_code, want);
        pending_results.push_back(want);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/keypad_code_lock_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad code lock unit test
// Sets a code, runs wrong entries through free retries, zero, short and long
// lockouts, and ends in an unlock, a permanent lock or a maximal lockout,
// with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module keypad_code_lock_unit_test;
  import kcl_pkg::*;
  import kcl_tb_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int SETTLE_CYCLES = 8;
  localparam int SQUEEZE_LEN   = 60;
  localparam int RUN_LIMIT_NS  = 4_000_000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic                  op        = OP_PRESS;
  logic [4:0]            key_code  = KEY_NONE_RAW;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            phase;
  logic [2:0]            event_res;
  logic [2:0]            digits_entered;
  logic [4:0]            failures;
  logic [15:0]           seconds_left;
  logic                  alarm;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FREE_TRIES;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int   fail_count;
  int   outstanding;
  logic squeeze = 1'b0;
  logic calm    = 1'b0;
  logic [4:0] code_raw [DIGITS];

  always #(CLK_PERIOD / 2) clk = ~clk;

  keypad_code_lock_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .key_code       (key_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .phase          (phase),
    .event_res      (event_res),
    .digits_entered (digits_entered),
    .failures       (failures),
    .seconds_left   (seconds_left),
    .alarm          (alarm),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  keypad_code_lock_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .key_code       (key_code),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .phase          (phase),
    .event_res      (event_res),
    .digits_entered (digits_entered),
    .failures       (failures),
    .seconds_left   (seconds_left),
    .alarm          (alarm),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  function automatic logic [4:0] pick_digit();
    return DIGIT_RAWS[4'($urandom_range(0, 9))];
  endfunction

  // Codes 0, 4 and 13 to 31 map to no key.
  function automatic logic [4:0] pick_unmapped();
    int unsigned r;
    r = $urandom_range(0, 20);
    if (r == 0) return KEY_NONE_RAW;
    if (r == 1) return 5'd4;
    return 5'(r + 11);
  endfunction

  // Valid stays high after a beat is taken; the caller either offers the
  // next beat in the same step or drops valid through drain.
  task automatic send_beat(input logic kind, input logic [4:0] raw);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    key_code <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 5) == 0) begin
      if ($urandom_range(0, 1) == 0) send_beat(OP_TICK, 5'($urandom_range(0, 31)));
      else send_beat(OP_PRESS, pick_unmapped());
    end
  endtask

  // An entry of len digits that never matches the code: short entries end
  // in equals, full ones differ from the code in at least one digit.
  task automatic send_wrong_entry(input int unsigned len);
    logic [4:0]  raws [DIGITS];
    logic        near;
    logic        same;
    int unsigned j;
    near = 1'($urandom_range(0, 1));
    same = (len == DIGITS);
    for (int i = 0; i < DIGITS; i++) begin
      raws[i] = near ? code_raw[i] : pick_digit();
      if (i < len && raws[i] != code_raw[i]) same = 1'b0;
    end
    if (same) begin
      j = $urandom_range(0, DIGITS - 1);
      while (raws[j] == code_raw[j]) raws[j] = pick_digit();
    end
    for (int i = 0; i < len; i++) begin
      maybe_noise();
      send_beat(OP_PRESS, raws[i]);
    end
    if (len < DIGITS) begin
      maybe_noise();
      send_beat(OP_PRESS, KEY_EQ_RAW);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: short random stalls, plus one long hold-off once asked.
  initial begin
    int  stall;
    logic squeezed;
    stall    = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        stall    = SQUEEZE_LEN;
      end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 4);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned long_lockout;
    int unsigned ticks_sent;
    int unsigned ending;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lowest settings: the first failure locks out for zero ticks.
    write_reg(CFG_FREE_TRIES, 16'd0);
    write_reg(CFG_LOCKOUT, 16'd0);
    send_beat(OP_TICK, 5'd31);
    send_beat(OP_PRESS, KEY_NONE_RAW);
    send_beat(OP_PRESS, KEY_EQ_RAW);
    send_beat(OP_PRESS, 5'd16);
    for (int i = 0; i < DIGITS; i++) begin
      code_raw[i] = pick_digit();
      send_beat(OP_PRESS, code_raw[i]);
      if (i == 1) send_beat(OP_PRESS, KEY_EQ_RAW);
    end
    send_beat(OP_PRESS, KEY_EQ_RAW);
    drain();

    // Two free retries and a three tick lockout.
    write_reg(CFG_FREE_TRIES, 16'd2);
    write_reg(CFG_LOCKOUT, 16'd3);
    send_wrong_entry(2);
    send_wrong_entry(DIGITS);
    send_beat(OP_PRESS, code_raw[0]);
    repeat (3) send_beat(OP_TICK, 5'($urandom_range(0, 31)));
    drain();

    // Long random stretch: retries up to a long lockout worked off by ticks.
    long_lockout = $urandom_range(1000, 1150);
    write_reg(CFG_FREE_TRIES, 16'd14);
    write_reg(CFG_LOCKOUT, 16'(long_lockout));
    repeat (12) send_wrong_entry($urandom_range(0, DIGITS));
    squeeze <= 1'b1;
    ticks_sent = 0;
    while (ticks_sent < long_lockout) begin
      if ($urandom_range(0, 7) == 0) begin
        send_beat(OP_PRESS, 5'($urandom_range(0, 31)));
      end else begin
        send_beat(OP_TICK, 5'($urandom_range(0, 31)));
        ticks_sent++;
      end
    end
    drain();

    // Final stretch without idling: unlock, permanent lock or maximal lockout.
    calm   <= 1'b1;
    ending = $urandom_range(0, 2);
    write_reg(CFG_FREE_TRIES, (ending == 1) ? 16'($urandom_range(0, 13)) : 16'd15);
    write_reg(CFG_LOCKOUT, 16'hFFFF);
    if (ending == 0) begin
      for (int i = 0; i < DIGITS; i++) begin
        maybe_noise();
        send_beat(OP_PRESS, code_raw[i]);
      end
    end else begin
      send_wrong_entry($urandom_range(0, DIGITS));
    end
    repeat (30) send_beat(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
    drain();

    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
